FILE: sv/tick_to_civil_date_time_macros.svh
// Assertion macros shared by the tick-to-date converter.
`ifndef TICK_TO_CIVIL_DATE_TIME_MACROS_SVH
`define TICK_TO_CIVIL_DATE_TIME_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TCDT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TCDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tcdt_pkg.sv
// Constants, types and lookup functions for the tick-to-date converter.
`default_nettype none

package tcdt_pkg;

  localparam int NumStages = 13;
  localparam int AddrW     = 3;

  // register index (paddr bit 2)
  localparam logic RegIdxEpoch = 1'b0;

  localparam logic [31:0] EpochReset = 32'd1767225600;
  localparam logic [19:0] DaysShift  = 20'd719468;
  localparam logic [19:0] DaysPerEra = 20'd146097;
  localparam logic [17:0] LastDoe    = 18'd146096;

  // Reciprocals: floor(x * R >> k) == floor(x / d) over the operand range used.
  localparam logic [29:0] Recip125  = 30'(((64'd1 << 36) + 64'd124) / 64'd125);
  localparam logic [26:0] Recip675  = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
  localparam logic [17:0] Recip7    = 18'(((64'd1 << 20) + 64'd6) / 64'd7);
  localparam logic [13:0] Recip225  = 14'(((64'd1 << 21) + 64'd224) / 64'd225);
  localparam logic [20:0] RecipEra  = 21'(((64'd1 << 38) + 64'd146096) / 64'd146097);
  localparam logic [10:0] Recip15   = 11'(((64'd1 << 14) + 64'd14) / 64'd15);
  localparam logic [16:0] Recip365a = 17'(((64'd1 << 25) + 64'd364) / 64'd365);
  localparam logic [16:0] Recip9131 = 17'(((64'd1 << 30) + 64'd9130) / 64'd9131);
  localparam logic [18:0] Recip365b = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [7:0]  Recip25   = 8'(((64'd1 << 12) + 64'd24) / 64'd25);

  typedef struct packed {
    logic [2:0] wday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millis;
  } clock_t;

  // day 0 of the count is a Thursday
  function automatic logic [2:0] weekday_of(input logic [2:0] rem);
    logic [2:0] wd;
    case (rem)
      3'd0:    wd = 3'd4;
      3'd1:    wd = 3'd5;
      3'd2:    wd = 3'd6;
      3'd3:    wd = 3'd0;
      3'd4:    wd = 3'd1;
      3'd5:    wd = 3'd2;
      3'd6:    wd = 3'd3;
      default: wd = 3'd0;
    endcase
    return wd;
  endfunction

  // first day of each month in a March-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // month index of a day of a March-based year
  function automatic logic [3:0] month_index(input logic [8:0] doy);
    logic [3:0] mp;
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= month_start(4'(k))) begin
        mp = 4'(k);
      end
    end
    return mp;
  endfunction

endpackage

`default_nettype wire

FILE: sv/tick_to_civil_date_time.sv
// Top level: pipelined conversion of a millisecond tick into calendar date and time.
//
//   channel   direction  handshake                      payload
//   -------   ---------  -----------------------------  -------------------------------
//   in        sink       in_valid_i / in_stall_o        tick_ms_i
//   out       source     out_valid_o / out_stall_i      year, month, day, weekday, time
//   apb       slave      psel/penable/pwrite/pready     epoch_seconds at byte address 0
//
// One request enters every cycle while the output is not stalled.
// The depth comes from the chain of reciprocal multiplies, at most one multiplier level per stage.
// A stall on the full output register freezes every stage at once and raises in_stall_o.
// Reset clears the stage valid bits and loads epoch_seconds with its reset value.
`default_nettype none

`include "tick_to_civil_date_time_macros.svh"

module tick_to_civil_date_time (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // request side
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [31:0]                tick_ms_i,
  // result side
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [11:0]                     year_o,
  output logic [3:0]                      month_o,
  output logic [4:0]                      day_of_month_o,
  output logic [2:0]                      weekday_o,
  output logic [4:0]                      hour_o,
  output logic [5:0]                      minute_o,
  output logic [5:0]                      second_o,
  output logic [9:0]                      millis_o,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tcdt_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tcdt_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [31:0] epoch_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegIdxEpoch);
  assign prdata = (paddr[2] == RegIdxEpoch) ? epoch_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q <= EpochReset;
    end else if (cfg_wr) begin
      epoch_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages advance together unless the output is blocked
  // ---------------------------------------------------------------------------
  logic [NumStages-1:0] v_q;
  logic                 adv;

  assign adv         = !(v_q[NumStages-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = v_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NumStages-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage registers
  // ---------------------------------------------------------------------------
  // s1: tick / 1000 product
  logic [31:0] tick1_q;
  logic [58:0] p125_q, p125_d;
  // s2: whole seconds plus epoch
  logic [9:0]  millis2_q, millis2_d;
  logic [32:0] sec2_q, sec2_d;
  // s3: seconds / 86400 product
  logic [9:0]  millis3_q;
  logic [32:0] sec3_q;
  logic [52:0] p675_q, p675_d;
  // s4: days and time of day
  logic [9:0]  millis4_q;
  logic [16:0] days4_q, days4_d;
  logic [16:0] tod4_q, tod4_d;
  logic [19:0] shift4_q, shift4_d;
  // s5: products for weekday, hour and era
  logic [9:0]  millis5_q;
  logic [16:0] days5_q;
  logic [16:0] tod5_q;
  logic [19:0] shift5_q;
  logic [34:0] p7_q, p7_d;
  logic [26:0] p225_q, p225_d;
  logic [40:0] pera_q, pera_d;
  // s6: weekday, hour, era, day of era
  logic [9:0]  millis6_q;
  logic [2:0]  wday6_q, wday6_d;
  logic [4:0]  hour6_q, hour6_d;
  logic [11:0] remh6_q, remh6_d;
  logic [2:0]  era6_q, era6_d;
  logic [17:0] doe6_q, doe6_d;
  // s7: products for minute and leap corrections
  logic [9:0]  millis7_q;
  logic [2:0]  wday7_q;
  logic [4:0]  hour7_q;
  logic [11:0] remh7_q;
  logic [2:0]  era7_q;
  logic [17:0] doe7_q;
  logic [20:0] p15_q, p15_d;
  logic [32:0] p1460_q, p1460_d;
  logic [32:0] p9131_q, p9131_d;
  // s8: full clock, corrected day count
  clock_t      clk8_q, clk8_d;
  logic [2:0]  era8_q;
  logic [17:0] doe8_q;
  logic [17:0] num8_q, num8_d;
  // s9: year of era product
  clock_t      clk9_q;
  logic [2:0]  era9_q;
  logic [17:0] doe9_q;
  logic [36:0] py_q, py_d;
  // s10: year of era, base year
  clock_t      clk10_q;
  logic [17:0] doe10_q;
  logic [8:0]  yoe10_q, yoe10_d;
  logic [11:0] ybase10_q, ybase10_d;
  // s11: day count at start of year
  clock_t      clk11_q;
  logic [17:0] doe11_q;
  logic [11:0] ybase11_q;
  logic [17:0] y365_q, y365_d;
  logic [14:0] p25_q, p25_d;
  // s12: day of year
  clock_t      clk12_q;
  logic [11:0] ybase12_q;
  logic [8:0]  doy12_q, doy12_d;
  // s13: output register
  clock_t      clk13_q;
  logic [11:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;

  // ---------------------------------------------------------------------------
  // Stage logic
  // ---------------------------------------------------------------------------
  logic [22:0] q1000;
  logic [16:0] days_w;
  logic [14:0] q7;
  logic [2:0]  rem7;
  logic [4:0]  hour_w;
  logic [2:0]  era_w;
  logic [5:0]  min_w;
  logic [8:0]  yoe_w;
  logic [3:0]  mp_w;

  always_comb begin
    // s1: tick / 1000 == (tick >> 3) / 125
    p125_d = {30'd0, tick_ms_i[31:3]} * {29'd0, Recip125};

    // s2: split off milliseconds, add the epoch without wrapping
    q1000     = p125_q[58:36];
    millis2_d = 10'(tick1_q - 32'({9'd0, q1000} * 32'd1000));
    sec2_d    = {10'd0, q1000} + {1'b0, epoch_q};

    // s3: seconds / 86400 == (seconds >> 7) / 675
    p675_d = {27'd0, sec2_q[32:7]} * {26'd0, Recip675};

    // s4: days, time of day, day count shifted to the March-based origin
    days_w   = p675_q[52:36];
    days4_d  = days_w;
    tod4_d   = 17'(sec3_q - 33'({16'd0, days_w} * 33'd86400));
    shift4_d = {3'd0, days_w} + DaysShift;

    // s5: days / 7, (tod >> 4) / 225, shifted / 146097
    p7_d   = {18'd0, days4_q} * {17'd0, Recip7};
    p225_d = {14'd0, tod4_q[16:4]} * {13'd0, Recip225};
    pera_d = {21'd0, shift4_q} * {20'd0, RecipEra};

    // s6: weekday, hour, era and day of era
    q7      = p7_q[34:20];
    rem7    = 3'(days5_q - 17'({2'd0, q7} * 17'd7));
    wday6_d = weekday_of(rem7);
    hour_w  = p225_q[25:21];
    hour6_d = hour_w;
    remh6_d = 12'(tod5_q - 17'({12'd0, hour_w} * 17'd3600));
    era_w   = pera_q[40:38];
    era6_d  = era_w;
    doe6_d  = 18'(shift5_q - 20'({17'd0, era_w} * DaysPerEra));

    // s7: (remh >> 2) / 15, doe / 1460 and doe / 36524
    p15_d   = {11'd0, remh6_q[11:2]} * {10'd0, Recip15};
    p1460_d = {17'd0, doe6_q[17:2]} * {16'd0, Recip365a};
    p9131_d = {17'd0, doe6_q[17:2]} * {16'd0, Recip9131};

    // s8: minute and second; drop the leap days from the day of era
    min_w         = p15_q[19:14];
    clk8_d.wday   = wday7_q;
    clk8_d.hour   = hour7_q;
    clk8_d.minute = min_w;
    clk8_d.second = 6'(remh7_q - 12'({6'd0, min_w} * 12'd60));
    clk8_d.millis = millis7_q;
    num8_d = doe7_q - {10'd0, p1460_q[32:25]} + {15'd0, p9131_q[32:30]}
             - {17'd0, doe7_q == LastDoe};

    // s9: year of era == corrected count / 365
    py_d = {19'd0, num8_q} * {18'd0, Recip365b};

    // s10: year of era and base year
    yoe_w     = py_q[35:27];
    yoe10_d   = yoe_w;
    ybase10_d = {3'd0, yoe_w} + 12'({9'd0, era9_q} * 12'd400);

    // s11: days before this year, yoe / 100 == (yoe >> 2) / 25
    y365_d = 18'({9'd0, yoe10_q} * 18'd365) + {11'd0, yoe10_q[8:2]};
    p25_d  = {8'd0, yoe10_q[8:2]} * {7'd0, Recip25};

    // s12: day of year
    doy12_d = 9'(doe11_q - y365_q + {15'd0, p25_q[14:12]});

    // s13: month and day; January and February belong to the next year
    mp_w    = month_index(doy12_q);
    day_d   = 5'(doy12_q - month_start(mp_w) + 9'd1);
    month_d = (mp_w < 4'd10) ? (mp_w + 4'd3) : (mp_w - 4'd9);
    year_d  = ybase12_q + {11'd0, month_d <= 4'd2};
  end

  // payload registers hold while the pipeline is frozen
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tick1_q   <= tick_ms_i;
      p125_q    <= p125_d;

      millis2_q <= millis2_d;
      sec2_q    <= sec2_d;

      millis3_q <= millis2_q;
      sec3_q    <= sec2_q;
      p675_q    <= p675_d;

      millis4_q <= millis3_q;
      days4_q   <= days4_d;
      tod4_q    <= tod4_d;
      shift4_q  <= shift4_d;

      millis5_q <= millis4_q;
      days5_q   <= days4_q;
      tod5_q    <= tod4_q;
      shift5_q  <= shift4_q;
      p7_q      <= p7_d;
      p225_q    <= p225_d;
      pera_q    <= pera_d;

      millis6_q <= millis5_q;
      wday6_q   <= wday6_d;
      hour6_q   <= hour6_d;
      remh6_q   <= remh6_d;
      era6_q    <= era6_d;
      doe6_q    <= doe6_d;

      millis7_q <= millis6_q;
      wday7_q   <= wday6_q;
      hour7_q   <= hour6_q;
      remh7_q   <= remh6_q;
      era7_q    <= era6_q;
      doe7_q    <= doe6_q;
      p15_q     <= p15_d;
      p1460_q   <= p1460_d;
      p9131_q   <= p9131_d;

      clk8_q    <= clk8_d;
      era8_q    <= era7_q;
      doe8_q    <= doe7_q;
      num8_q    <= num8_d;

      clk9_q    <= clk8_q;
      era9_q    <= era8_q;
      doe9_q    <= doe8_q;
      py_q      <= py_d;

      clk10_q   <= clk9_q;
      doe10_q   <= doe9_q;
      yoe10_q   <= yoe10_d;
      ybase10_q <= ybase10_d;

      clk11_q   <= clk10_q;
      doe11_q   <= doe10_q;
      ybase11_q <= ybase10_q;
      y365_q    <= y365_d;
      p25_q     <= p25_d;

      clk12_q   <= clk11_q;
      ybase12_q <= ybase11_q;
      doy12_q   <= doy12_d;

      clk13_q   <= clk12_q;
      year_q    <= year_d;
      month_q   <= month_d;
      day_q     <= day_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = day_q;
  assign weekday_o      = clk13_q.wday;
  assign hour_o         = clk13_q.hour;
  assign minute_o       = clk13_q.minute;
  assign second_o       = clk13_q.second;
  assign millis_o       = clk13_q.millis;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TCDT_ASSERT_IMPLIES(a_backpressure, out_valid_o && out_stall_i, in_stall_o, "request taken while output blocked")
  `TCDT_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, v_q[0], "accepted request missing from first stage")
  `TCDT_ASSERT_IMPLIES(a_date_range, out_valid_o, (month_o != 4'd0) && (month_o <= 4'd12) && (day_of_month_o != 5'd0) && (weekday_o <= 3'd6), "date field out of range")
  `TCDT_ASSERT_IMPLIES(a_clock_range, out_valid_o, (hour_o < 5'd24) && (minute_o < 6'd60) && (second_o < 6'd60) && (millis_o < 10'd1000), "time field out of range")

endmodule

`default_nettype wire
